// ===== rtl/sbh_pkg.sv =====
// shared types, constants and the mixing microcode for the string hash bucket block
package sbh_pkg;

	// input and result words
	typedef struct packed {
		logic [15:0] key_length;
		logic [31:0] chunk;
		logic [2:0]  chunk_bytes;
		logic        last_chunk;
	} sbh_in_t;

	typedef struct packed {
		logic [31:0] bucket;
		logic        length_error;
	} sbh_out_t;

	localparam int unsigned MAX_KEY_BYTES    = 32'd65535;
	localparam logic [2:0]  FULL_CHUNK_BYTES = 3'd4;
	localparam int unsigned MIX_HI_SHIFT     = 11;

	// microcode program counter and entry points
	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] sbh_pc_t;

	localparam sbh_pc_t PC_FULL  = 5'd0;
	localparam sbh_pc_t PC_TAIL3 = 5'd3;
	localparam sbh_pc_t PC_TAIL2 = 5'd7;
	localparam sbh_pc_t PC_TAIL1 = 5'd10;
	localparam sbh_pc_t PC_AVAL  = 5'd13;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_XOR = 1'b1
	} sbh_op_t;

	typedef enum logic [2:0] {
		SRC_SHL     = 3'd0,
		SRC_SHR     = 3'd1,
		SRC_LO16    = 3'd2,
		SRC_SEXT_LO = 3'd3,
		SRC_SEXT_HI = 3'd4,
		SRC_MIX     = 3'd5
	} sbh_src_t;

	typedef enum logic [1:0] {
		NXT_STEP       = 2'd0,
		NXT_AVAL       = 2'd1,
		NXT_CHUNK_DONE = 2'd2,
		NXT_HASH_DONE  = 2'd3
	} sbh_nxt_t;

	typedef struct packed {
		sbh_op_t    op;
		sbh_src_t   src;
		logic [4:0] shamt;
		sbh_nxt_t   nxt;
	} sbh_uop_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sbh_div_stat_t;

	// one alu step per entry: h = h op operand
	function automatic sbh_uop_t sbh_uop(input sbh_pc_t pc);
		sbh_uop_t u;
		unique case (pc)
			PC_FULL:          u = '{OP_ADD, SRC_LO16,    5'd0,  NXT_STEP};
			PC_FULL  + 5'd1:  u = '{OP_XOR, SRC_MIX,     5'd16, NXT_STEP};
			PC_FULL  + 5'd2:  u = '{OP_ADD, SRC_SHR,     5'd11, NXT_CHUNK_DONE};
			PC_TAIL3:         u = '{OP_ADD, SRC_LO16,    5'd0,  NXT_STEP};
			PC_TAIL3 + 5'd1:  u = '{OP_XOR, SRC_SHL,     5'd16, NXT_STEP};
			PC_TAIL3 + 5'd2:  u = '{OP_XOR, SRC_SEXT_HI, 5'd18, NXT_STEP};
			PC_TAIL3 + 5'd3:  u = '{OP_ADD, SRC_SHR,     5'd11, NXT_AVAL};
			PC_TAIL2:         u = '{OP_ADD, SRC_LO16,    5'd0,  NXT_STEP};
			PC_TAIL2 + 5'd1:  u = '{OP_XOR, SRC_SHL,     5'd11, NXT_STEP};
			PC_TAIL2 + 5'd2:  u = '{OP_ADD, SRC_SHR,     5'd17, NXT_AVAL};
			PC_TAIL1:         u = '{OP_ADD, SRC_SEXT_LO, 5'd0,  NXT_STEP};
			PC_TAIL1 + 5'd1:  u = '{OP_XOR, SRC_SHL,     5'd10, NXT_STEP};
			PC_TAIL1 + 5'd2:  u = '{OP_ADD, SRC_SHR,     5'd1,  NXT_AVAL};
			PC_AVAL:          u = '{OP_XOR, SRC_SHL,     5'd3,  NXT_STEP};
			PC_AVAL  + 5'd1:  u = '{OP_ADD, SRC_SHR,     5'd5,  NXT_STEP};
			PC_AVAL  + 5'd2:  u = '{OP_XOR, SRC_SHL,     5'd4,  NXT_STEP};
			PC_AVAL  + 5'd3:  u = '{OP_ADD, SRC_SHR,     5'd17, NXT_STEP};
			PC_AVAL  + 5'd4:  u = '{OP_XOR, SRC_SHL,     5'd25, NXT_STEP};
			PC_AVAL  + 5'd5:  u = '{OP_ADD, SRC_SHR,     5'd6,  NXT_HASH_DONE};
			default:          u = '{OP_XOR, SRC_SHR,     5'd0,  NXT_CHUNK_DONE};
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/string_hash_bucket.sv =====
// string_hash_bucket: hashes a chunked byte key and reduces it to a table bucket
//
// in channel: one word per 4-byte key chunk; the first word of a key carries key_length,
// full chunks have last_chunk 0 and 4 bytes, the final word holds the 0 to 3 tail bytes.
// out channel: one word per finished key (bucket) or per malformed word (length_error).
// cfg channel: cfg_data writes table_size; cfg_ready is always high, write only when idle.
// a full chunk keeps in_ready low while the mixing microcode runs on the
// shared alu. a last chunk runs 9 or 10 alu steps (tail rule plus avalanche), then the
// bit-serial remainder unit reduces the hash to the bucket word. a malformed word gives
// its error word on the next cycle.
// in_ready is also low while a result word waits and out_ready is low, so a stalled
// receiver holds the block after at most one pending word.
// reset clears the running hash and key state, sets table_size to 1024 and drops
// out_valid.
module string_hash_bucket
	import sbh_pkg::*;
#(
	parameter int HASH_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sbh_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output sbh_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MIX  = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t                state_q;
	sbh_pc_t               pc_q;
	logic [HASH_WIDTH-1:0] hash_q;
	logic [15:0]           bytes_left_q;
	logic                  in_key_q;
	logic [31:0]           chunk_q;
	logic [31:0]           table_size_q;
	logic                  out_valid_q;
	sbh_out_t              out_data_q;

	logic                  in_fire;
	logic [HASH_WIDTH-1:0] h_start;
	logic [15:0]           bl_start;
	logic [15:0]           nb_ext;
	logic                  too_long;
	logic                  chunk_bad;
	logic                  accept_fail;
	sbh_pc_t               start_pc;
	sbh_uop_t              uop;
	logic [HASH_WIDTH-1:0] alu_h;
	logic                  div_start;
	sbh_div_stat_t         div_stat;
	logic [31:0]           div_rem;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// first word of a key seeds hash and byte count from key_length
	always_comb begin
		h_start  = in_key_q ? hash_q : HASH_WIDTH'(in_data.key_length);
		bl_start = in_key_q ? bytes_left_q : in_data.key_length;
		nb_ext   = 16'(in_data.chunk_bytes);
		too_long = !in_key_q && (32'(in_data.key_length) > MAX_KEY_BYTES);
		if (!in_data.last_chunk) begin
			chunk_bad = (in_data.chunk_bytes != FULL_CHUNK_BYTES) || (bl_start < 16'd4);
		end else begin
			chunk_bad = (nb_ext != bl_start) || (bl_start > 16'd3);
		end
		accept_fail = too_long || chunk_bad;
		if (!in_data.last_chunk) begin
			start_pc = PC_FULL;
		end else begin
			case (in_data.chunk_bytes)
				3'd3:    start_pc = PC_TAIL3;
				3'd2:    start_pc = PC_TAIL2;
				default: start_pc = PC_TAIL1;
			endcase
		end
	end

	assign uop = sbh_uop(pc_q);

	sbh_mix_alu #(
		.W(HASH_WIDTH)
	) u_alu (
		.uop    (uop),
		.h      (hash_q),
		.chunk  (chunk_q),
		.h_next (alu_h)
	);

	assign div_start = (state_q == ST_MIX) && (uop.nxt == NXT_HASH_DONE);

	sbh_divider #(
		.DW(HASH_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (alu_h),
		.divisor   (table_size_q),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pc_q         <= PC_FULL;
			hash_q       <= '0;
			bytes_left_q <= '0;
			in_key_q     <= 1'b0;
			table_size_q <= 32'd1024;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				table_size_q <= cfg_data;
			end
			// a new result word may load on the edge that hands off the old one
			if ((in_fire && accept_fail) || ((state_q == ST_DIV) && div_stat.done)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (accept_fail) begin
							in_key_q     <= 1'b0;
							bytes_left_q <= '0;
							hash_q       <= '0;
						end else begin
							hash_q  <= h_start;
							pc_q    <= start_pc;
							state_q <= ST_MIX;
							if (in_data.last_chunk) begin
								in_key_q     <= 1'b0;
								bytes_left_q <= '0;
							end else begin
								in_key_q     <= 1'b1;
								bytes_left_q <= bl_start - 16'd4;
							end
						end
					end
				end
				ST_MIX: begin
					case (uop.nxt)
						NXT_STEP: begin
							hash_q <= alu_h;
							pc_q   <= pc_q + 1'b1;
						end
						NXT_AVAL: begin
							hash_q <= alu_h;
							pc_q   <= PC_AVAL;
						end
						NXT_CHUNK_DONE: begin
							hash_q  <= alu_h;
							state_q <= ST_IDLE;
						end
						default: begin
							// hash goes to the divider, running state starts over
							hash_q  <= '0;
							state_q <= ST_DIV;
						end
					endcase
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			// a zero-byte tail mixes a zero byte
			if (in_data.last_chunk && (in_data.chunk_bytes == 3'd0)) begin
				chunk_q <= '0;
			end else begin
				chunk_q <= in_data.chunk;
			end
			if (accept_fail) begin
				out_data_q.bucket       <= '0;
				out_data_q.length_error <= 1'b1;
			end
		end else if ((state_q == ST_DIV) && div_stat.done) begin
			out_data_q.bucket       <= (table_size_q == '0) ? '0 : div_rem;
			out_data_q.length_error <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_err_zero_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.length_error |-> out_data.bucket == '0)
		else $error("error word with nonzero bucket");

	a_bucket_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.length_error && table_size_q != '0
		|-> out_data.bucket < table_size_q)
		else $error("bucket not below table size");

	a_busy_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX || state_q == ST_DIV) |-> !out_valid_q)
		else $error("result word pending while a word is in work");

	a_div_tracks_fsm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_stat.busy || div_stat.done)
		else $error("divider idle during divide state");

	a_div_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == ST_DIV && div_stat.busy)
		else $error("divider did not start");
`endif

endmodule

// ===== rtl/sbh_mix_alu.sv =====
// shared add/xor/shift unit that performs one hash mixing step per cycle
module sbh_mix_alu
	import sbh_pkg::*;
#(
	parameter int W = 64
) (
	input  sbh_uop_t     uop,
	input  logic [W-1:0] h,
	input  logic [31:0]  chunk,
	output logic [W-1:0] h_next
);

	logic [W-1:0] operand;
	logic [W-1:0] sext_lo;
	logic [W-1:0] sext_hi;
	logic [W-1:0] hi_mix;

	// tail bytes count as signed char
	assign sext_lo = {{(W-8){chunk[7]}}, chunk[7:0]};
	assign sext_hi = {{(W-8){chunk[23]}}, chunk[23:16]} << uop.shamt;
	assign hi_mix  = W'(chunk[31:16]) << MIX_HI_SHIFT;

	always_comb begin
		case (uop.src)
			SRC_SHL:     operand = h << uop.shamt;
			SRC_SHR:     operand = h >> uop.shamt;
			SRC_LO16:    operand = W'(chunk[15:0]);
			SRC_SEXT_LO: operand = sext_lo;
			SRC_SEXT_HI: operand = sext_hi;
			SRC_MIX:     operand = (h << uop.shamt) ^ hi_mix;
			default:     operand = '0;
		endcase
		h_next = (uop.op == OP_XOR) ? (h ^ operand) : (h + operand);
	end

endmodule

// ===== rtl/sbh_divider.sv =====
// restoring divider, one quotient bit per cycle, keeps only the remainder
module sbh_divider
	import sbh_pkg::*;
#(
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output sbh_div_stat_t stat,
	output logic [31:0]   remainder
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW-1:0]    dvd_q;
	logic [31:0]      rem_q;
	logic [32:0]      trial;
	logic [32:0]      diff;
	logic [31:0]      rem_next;

	assign trial    = {rem_q, dvd_q[DW-1]};
	assign diff     = trial - {1'b0, divisor};
	assign rem_next = (trial >= {1'b0, divisor}) ? diff[31:0] : trial[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule
